@@ src/tar_pkg.sv @@
// shared constants, types and sequencer codes for the triangular arbitrage block
`timescale 1ns / 1ps

package tar_pkg;

	localparam int FRAC_BITS = 40;
	localparam int WORD_W    = 64;
	localparam int HALF_W    = WORD_W / 2;
	localparam int FEE_W     = 41;
	localparam int ACC_W     = 2 * WORD_W;
	localparam int IDX_W     = 2;

	localparam logic [WORD_W-1:0] ONE      = WORD_W'(1) << FRAC_BITS;
	localparam logic [WORD_W-1:0] ALL_ONES = '1;

	// default fee is 0.99925 cubed at 40 fraction bits, rescaled to FRAC_BITS
	localparam logic [WORD_W-1:0] FEE_AT_40 = 64'd1097039581575;
	localparam logic [FEE_W-1:0]  FEE_RESET = (FRAC_BITS >= 40) ?
		FEE_W'(FEE_AT_40 << (FRAC_BITS - 40)) : FEE_W'(FEE_AT_40 >> (40 - FRAC_BITS));

	// dividend 2^(2*FRAC_BITS) split into a starting remainder and a low word
	localparam logic [WORD_W-1:0] RECIP_HI = (2 * FRAC_BITS >= WORD_W) ?
		(WORD_W'(1) << (2 * FRAC_BITS - WORD_W)) : '0;
	localparam logic [WORD_W-1:0] RECIP_LO = (2 * FRAC_BITS >= WORD_W) ?
		'0 : (WORD_W'(1) << (2 * FRAC_BITS));

	localparam int DIV_STEPS = WORD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [IDX_W-1:0] CUR_0     = 2'd0;
	localparam logic [IDX_W-1:0] CUR_1     = 2'd1;
	localparam logic [IDX_W-1:0] CUR_2     = 2'd2;
	localparam logic [IDX_W-1:0] CUR_COUNT = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ISSUE,
		ST_WAIT,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		STEP_F_AB,
		STEP_F_C,
		STEP_F_FEE,
		STEP_B_AB,
		STEP_B_C,
		STEP_B_FEE
	} step_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] op_a;
		logic [WORD_W-1:0] op_b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic              sat;
		logic [WORD_W-1:0] product;
	} mul_rsp_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ src/triangular_arbitrage_returns.sv @@
// top level: rate table, sequencer and result register of the arbitrage block
// the divider retires one quotient bit a cycle; each of the six multiplies runs on the
// one shared 32x32 multiplier; no new item is taken until the last result is loaded
// reset: all rates 1.0, fee factor 0.99925 cubed, no result pending
`timescale 1ns / 1ps

module triangular_arbitrage_returns import tar_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [FEE_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [IDX_W-1:0]  from_currency,
	input  logic [IDX_W-1:0]  to_currency,
	input  logic [WORD_W-1:0] buy_price,
	input  logic [WORD_W-1:0] sell_price,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] forward_return,
	output logic [WORD_W-1:0] backward_return,
	output logic              saturated,
	output logic              zero_sell
);

	state_t            state_q, state_d;
	step_t             step_q, step_d;
	logic [WORD_W-1:0] rate_q [CUR_COUNT][CUR_COUNT];
	logic [FEE_W-1:0]  fee_q;
	logic [IDX_W-1:0]  from_q;
	logic [IDX_W-1:0]  to_q;
	logic              zero_q;
	logic              sat_q;
	logic [WORD_W-1:0] chain_q;
	logic [WORD_W-1:0] fwd_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] fwd_out_q;
	logic [WORD_W-1:0] bwd_out_q;
	logic              sat_out_q;
	logic              zero_out_q;

	logic              in_xfer;
	logic              idx_ok;
	logic              sell_is_zero;
	logic              recip_sat;
	logic              need_div;
	logic              mul_start;
	logic              div_start;
	logic              out_load;
	logic [WORD_W-1:0] op_a;
	logic [WORD_W-1:0] op_b;
	mul_req_t          mul_req;
	mul_rsp_t          mul_rsp;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;

	always_comb begin
		idx_ok       = (from_currency < CUR_COUNT) && (to_currency < CUR_COUNT);
		sell_is_zero = (sell_price == '0);
		// quotient of 2^(2*FRAC_BITS) would not fit in 64 bits
		recip_sat    = idx_ok && !sell_is_zero && (sell_price <= RECIP_HI);
		need_div     = idx_ok && !sell_is_zero && !recip_sat;
	end

	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					div_start = need_div;
					step_d    = STEP_F_AB;
					state_d   = need_div ? ST_DIV : ST_ISSUE;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				mul_start = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (mul_rsp.done) begin
					if (step_q == STEP_B_FEE) begin
						state_d = ST_DONE;
					end else begin
						step_d  = step_t'(step_q + 3'd1);
						state_d = ST_ISSUE;
					end
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// forward cycle r01*r12*r20*fee, then backward r02*r21*r10*fee
	always_comb begin
		unique case (step_q)
			STEP_F_AB: begin
				op_a = rate_q[CUR_0][CUR_1];
				op_b = rate_q[CUR_1][CUR_2];
			end
			STEP_F_C: begin
				op_a = chain_q;
				op_b = rate_q[CUR_2][CUR_0];
			end
			STEP_F_FEE: begin
				op_a = chain_q;
				op_b = {{(WORD_W-FEE_W){1'b0}}, fee_q};
			end
			STEP_B_AB: begin
				op_a = rate_q[CUR_0][CUR_2];
				op_b = rate_q[CUR_2][CUR_1];
			end
			STEP_B_C: begin
				op_a = chain_q;
				op_b = rate_q[CUR_1][CUR_0];
			end
			STEP_B_FEE: begin
				op_a = chain_q;
				op_b = {{(WORD_W-FEE_W){1'b0}}, fee_q};
			end
			default: begin
				op_a = chain_q;
				op_b = '0;
			end
		endcase
	end

	assign mul_req = '{start: mul_start, op_a: op_a, op_b: op_b};
	assign div_req = '{start: div_start, divisor: sell_price};

	tar_qmul u_qmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	tar_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_F_AB;
			out_valid_q <= 1'b0;
			fee_q       <= FEE_RESET;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				fee_q <= cfg_wdata;
			end
		end
	end

	// a same-currency update with a saturated reciprocal keeps only the reciprocal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < CUR_COUNT; r++) begin
				for (int c = 0; c < CUR_COUNT; c++) begin
					rate_q[r][c] <= ONE;
				end
			end
		end else begin
			if (in_xfer && idx_ok && !(recip_sat && (from_currency == to_currency))) begin
				rate_q[from_currency][to_currency] <= buy_price;
			end
			if (in_xfer && recip_sat) begin
				rate_q[to_currency][from_currency] <= ALL_ONES;
			end
			if (state_q == ST_DIV && div_rsp.done) begin
				rate_q[to_q][from_q] <= div_rsp.quotient;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			from_q <= from_currency;
			to_q   <= to_currency;
			zero_q <= sell_is_zero;
			sat_q  <= recip_sat;
		end
		if (state_q == ST_WAIT && mul_rsp.done) begin
			chain_q <= mul_rsp.product;
			sat_q   <= sat_q | mul_rsp.sat;
			if (step_q == STEP_F_FEE) begin
				fwd_q <= mul_rsp.product;
			end
		end
		if (out_load) begin
			fwd_out_q  <= fwd_q;
			bwd_out_q  <= chain_q;
			sat_out_q  <= sat_q;
			zero_out_q <= zero_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign forward_return  = fwd_out_q;
	assign backward_return = bwd_out_q;
	assign saturated       = sat_out_q;
	assign zero_sell       = zero_out_q;

endmodule

@@ src/tar_qmul.sv @@
// iterative fixed-point multiplier on one shared 32x32 multiplier, saturating
`timescale 1ns / 1ps

module tar_qmul import tar_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	localparam logic [2:0] MUL_LAST = 3'd4;

	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] b_q;
	logic [WORD_W-1:0] prod_s1;
	logic [ACC_W-1:0]  acc_q;
	logic [2:0]        cnt_q;
	logic              run_q;
	logic              done_q;
	logic [HALF_W-1:0] a_half;
	logic [HALF_W-1:0] b_half;
	logic [ACC_W-1:0]  addend;

	// partial order: lo*lo, lo*hi, hi*lo, hi*hi
	always_comb begin
		a_half = cnt_q[1] ? a_q[WORD_W-1:HALF_W] : a_q[HALF_W-1:0];
		b_half = cnt_q[0] ? b_q[WORD_W-1:HALF_W] : b_q[HALF_W-1:0];
		unique case (cnt_q)
			3'd1:       addend = {{WORD_W{1'b0}}, prod_s1};
			3'd2, 3'd3: addend = {{HALF_W{1'b0}}, prod_s1, {HALF_W{1'b0}}};
			3'd4:       addend = {prod_s1, {WORD_W{1'b0}}};
			default:    addend = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == MUL_LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.op_a;
			b_q   <= req.op_b;
			acc_q <= '0;
		end else if (run_q) begin
			prod_s1 <= {{HALF_W{1'b0}}, a_half} * {{HALF_W{1'b0}}, b_half};
			acc_q   <= acc_q + addend;
		end
	end

	always_comb begin
		rsp.done    = done_q;
		rsp.sat     = |acc_q[ACC_W-1:WORD_W+FRAC_BITS];
		rsp.product = rsp.sat ? ALL_ONES : acc_q[WORD_W+FRAC_BITS-1:FRAC_BITS];
	end

endmodule

@@ src/tar_recip.sv @@
// bit-serial restoring divider for the fixed-point reciprocal of the sell price
`timescale 1ns / 1ps

module tar_recip import tar_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	logic [WORD_W-1:0]    rem_q;
	logic [WORD_W-1:0]    dq_q;
	logic [WORD_W-1:0]    d_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [WORD_W:0]      trial;
	logic [WORD_W:0]      diff;
	logic                 ge;

	// dividend bits shift out of the top of dq_q, quotient bits shift in below
	always_comb begin
		trial = {rem_q, dq_q[WORD_W-1]};
		diff  = trial - {1'b0, d_q};
		ge    = trial >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= RECIP_HI;
			dq_q  <= RECIP_LO;
			d_q   <= req.divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
			dq_q  <= {dq_q[WORD_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q;

endmodule

@@ src/tar_checker.sv @@
// port-level checks on the arbitrage block, bound to the top level
`timescale 1ns / 1ps

module tar_checker import tar_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [WORD_W-1:0] forward_return,
	input logic [WORD_W-1:0] backward_return,
	input logic              saturated,
	input logic              zero_sell
);

	// block is busy right after taking an item
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after transfer");

	// the six multiplies on the one shared multiplier keep the block busy after an item
	a_min_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> ##42 in_stall)
		else $error("item finished too early");

	// a new result only appears at the end of an item's work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without item in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(forward_return)
			&& $stable(backward_return) && $stable(saturated) && $stable(zero_sell)))
		else $error("stalled result changed");

endmodule

bind triangular_arbitrage_returns tar_checker u_tar_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.forward_return  (forward_return),
	.backward_return (backward_return),
	.saturated       (saturated),
	.zero_sell       (zero_sell)
);

@@ sim/tb.sv @@
// self-checking testbench for the triangular arbitrage cycle-return block
`timescale 1ns / 1ps

module tb import tar_pkg::*; ;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 500;
	localparam int TAIL_CYCLES = 120;
	localparam logic [FEE_W-1:0] FEE_ONE = FEE_W'(ONE);

	typedef struct {
		logic [IDX_W-1:0]  from_cur;
		logic [IDX_W-1:0]  to_cur;
		logic [WORD_W-1:0] buy;
		logic [WORD_W-1:0] sell;
		int                gap;
		bit                drain_first;
	} rate_update_t;

	typedef struct {
		logic [WORD_W-1:0] forward;
		logic [WORD_W-1:0] backward;
		logic              sat;
		logic              zero;
	} cycle_returns_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [FEE_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [IDX_W-1:0]  from_currency = '0;
	logic [IDX_W-1:0]  to_currency = '0;
	logic [WORD_W-1:0] buy_price = '0;
	logic [WORD_W-1:0] sell_price = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [WORD_W-1:0] forward_return;
	logic [WORD_W-1:0] backward_return;
	logic              saturated;
	logic              zero_sell;

	triangular_arbitrage_returns dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.from_currency   (from_currency),
		.to_currency     (to_currency),
		.buy_price       (buy_price),
		.sell_price      (sell_price),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.forward_return  (forward_return),
		.backward_return (backward_return),
		.saturated       (saturated),
		.zero_sell       (zero_sell)
	);

	// predictor state
	logic [WORD_W-1:0] rate_book [9];
	logic [FEE_W-1:0]  fee_now;

	rate_update_t   update_q [$];
	cycle_returns_t pending_returns [$];

	rate_update_t drv_item;
	bit           drv_loaded = 1'b0;
	int           drv_gap = 0;
	bit           in_fired = 1'b0;
	bit           out_fired = 1'b0;
	bit           calm = 1'b0;
	bit           drain_next = 1'b0;
	bit           rx_hold_req = 1'b0;
	int           rx_hold_left = 0;
	int           rx_wait = 0;

	int cycle_count = 0;
	int errors = 0;
	int updates_sent = 0;
	int results_checked = 0;
	int sat_seen = 0;
	int zero_seen = 0;
	int fee_settings = 0;
	int sender_pauses = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// fixed-point multiply, truncating, saturating on overflow
	function automatic logic [WORD_W-1:0] fx_mul(input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b, inout logic sat);
		logic [ACC_W-1:0] p;
		p = ACC_W'(a) * ACC_W'(b);
		if (p[ACC_W-1:FRAC_BITS+WORD_W] != '0) begin
			sat = 1'b1;
			return ALL_ONES;
		end
		return p[FRAC_BITS+WORD_W-1:FRAC_BITS];
	endfunction

	// floor(2^(2*FRAC_BITS) / d), saturating when the quotient needs more than a word
	function automatic logic [WORD_W-1:0] fx_recip(input logic [WORD_W-1:0] d,
		inout logic sat);
		logic [ACC_W-1:0] q;
		q = (ACC_W'(1) << (2 * FRAC_BITS)) / ACC_W'(d);
		if (q[ACC_W-1:WORD_W] != '0) begin
			sat = 1'b1;
			return ALL_ONES;
		end
		return q[WORD_W-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] rate_at(input logic [IDX_W-1:0] x,
		input logic [IDX_W-1:0] y);
		return rate_book[int'(x) * 3 + int'(y)];
	endfunction

	function automatic logic [WORD_W-1:0] cycle_return(input logic [WORD_W-1:0] r1,
		input logic [WORD_W-1:0] r2, input logic [WORD_W-1:0] r3, inout logic sat);
		logic [WORD_W-1:0] p;
		p = fx_mul(r1, r2, sat);
		p = fx_mul(p, r3, sat);
		return fx_mul(p, WORD_W'(fee_now), sat);
	endfunction

	task automatic apply_update(input logic [IDX_W-1:0] f, input logic [IDX_W-1:0] t,
		input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] s);
		cycle_returns_t r;
		logic sat;
		sat = 1'b0;
		// an index of three leaves the table alone
		if (f < CUR_COUNT && t < CUR_COUNT) begin
			rate_book[int'(f) * 3 + int'(t)] = b;
			if (s != '0)
				rate_book[int'(t) * 3 + int'(f)] = fx_recip(s, sat);
		end
		r.forward  = cycle_return(rate_at(CUR_0, CUR_1), rate_at(CUR_1, CUR_2),
			rate_at(CUR_2, CUR_0), sat);
		r.backward = cycle_return(rate_at(CUR_0, CUR_2), rate_at(CUR_2, CUR_1),
			rate_at(CUR_1, CUR_0), sat);
		r.sat  = sat;
		r.zero = (s == '0);
		pending_returns.push_back(r);
		updates_sent++;
		if (sat)
			sat_seen++;
		if (r.zero)
			zero_seen++;
	endtask

	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
		input logic [WORD_W-1:0] want_v);
		$display("mismatch on %s: got %h, want %h at %0t", what, got, want_v, $time);
		errors++;
	endtask

	task automatic queue_update(input logic [IDX_W-1:0] f, input logic [IDX_W-1:0] t,
		input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] s);
		rate_update_t u;
		u.from_cur    = f;
		u.to_cur      = t;
		u.buy         = b;
		u.sell        = s;
		u.gap         = calm ? 0 : int'($urandom_range(0, 4));
		u.drain_first = drain_next;
		drain_next    = 1'b0;
		update_q.push_back(u);
	endtask

	// rates spread around 1.0, from well below to well above
	function automatic logic [WORD_W-1:0] market_price();
		logic [WORD_W-1:0] m;
		m = WORD_W'($urandom);
		return m << $urandom_range(4, 16);
	endfunction

	task automatic queue_random(input int n);
		logic [WORD_W-1:0] r;
		logic [IDX_W-1:0]  f;
		logic [IDX_W-1:0]  t;
		int kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 9);
			f = IDX_W'($urandom_range(0, 2));
			t = IDX_W'($urandom_range(0, 2));
			r = market_price();
			if (kind <= 6) begin
				queue_update(f, t, r, r + (r >> $urandom_range(6, 12)));
			end else if (kind == 7) begin
				queue_update(f, t, {$urandom, $urandom}, {$urandom, $urandom});
			end else if (kind == 8) begin
				// zero or tiny sell price; a nonzero price up to 2^16 saturates the reciprocal
				queue_update(f, t, r, ($urandom_range(0, 1) == 0) ? '0 :
					WORD_W'($urandom_range(0, 131072)));
			end else begin
				if ($urandom_range(0, 1) == 0)
					f = CUR_COUNT;
				else
					t = CUR_COUNT;
				queue_update(f, t, {$urandom, $urandom},
					($urandom_range(0, 3) == 0) ? '0 : {$urandom, $urandom});
			end
		end
	endtask

	task automatic wait_idle();
		while (update_q.size() != 0 || drv_loaded || pending_returns.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_fee(input logic [FEE_W-1:0] v);
		@(negedge clk);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we  <= 1'b0;
		fee_now = v;
		fee_settings++;
	endtask

	function automatic logic [FEE_W-1:0] random_fee();
		logic [FEE_W-1:0] v;
		v = FEE_W'({$urandom, $urandom});
		if (v > FEE_ONE)
			v = v - FEE_ONE;
		return v;
	endfunction

	// input side: one transfer per queued item, optional gap before each
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_fired) begin
				in_fired   = 1'b0;
				drv_loaded = 1'b0;
			end
			if (!drv_loaded && update_q.size() > 0 &&
				(!update_q[0].drain_first || pending_returns.size() == 0)) begin
				drv_item   = update_q.pop_front();
				drv_gap    = drv_item.gap;
				drv_loaded = 1'b1;
				if (drv_item.drain_first)
					sender_pauses++;
			end
			if (drv_loaded && drv_gap > 0) begin
				drv_gap--;
				in_valid <= 1'b0;
			end else begin
				in_valid <= drv_loaded;
			end
			from_currency <= drv_item.from_cur;
			to_currency   <= drv_item.to_cur;
			buy_price     <= drv_item.buy;
			sell_price    <= drv_item.sell;
		end
	end

	// result side: random stall after each transfer, plus long hold-offs on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fired) begin
				out_fired = 1'b0;
				rx_wait   = calm ? 0 : int'($urandom_range(0, 4));
			end
			if (rx_hold_req) begin
				rx_hold_req  = 1'b0;
				rx_hold_left = HOLD_CYCLES;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				out_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		cycle_returns_t want;
		if (arst_n) begin
			cycle_count++;
			if (out_valid && !out_stall) begin
				out_fired = 1'b1;
				if (pending_returns.size() == 0) begin
					report_mismatch("result with nothing pending", forward_return, '0);
				end else begin
					want = pending_returns.pop_front();
					if (forward_return !== want.forward)
						report_mismatch("forward_return", forward_return, want.forward);
					if (backward_return !== want.backward)
						report_mismatch("backward_return", backward_return, want.backward);
					if (saturated !== want.sat)
						report_mismatch("saturated", WORD_W'(saturated), WORD_W'(want.sat));
					if (zero_sell !== want.zero)
						report_mismatch("zero_sell", WORD_W'(zero_sell), WORD_W'(want.zero));
					results_checked++;
				end
			end
			if (in_valid && !in_stall) begin
				in_fired = 1'b1;
				apply_update(from_currency, to_currency, buy_price, sell_price);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			pending_returns.size());
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		for (int i = 0; i < 9; i++)
			rate_book[i] = ONE;
		fee_now = FEE_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: identities, extremes, reciprocal edges, diagonal and index three
		queue_update(CUR_0, CUR_1, ONE, ONE);
		queue_update(CUR_1, CUR_2, ONE, ONE);
		queue_update(CUR_2, CUR_0, ONE << 1, ONE >> 1);
		queue_update(CUR_0, CUR_2, '0, '0);
		queue_update(CUR_2, CUR_1, ALL_ONES, ALL_ONES);
		queue_update(CUR_1, CUR_0, ONE, 64'd1);
		queue_update(CUR_1, CUR_0, ONE, 64'h1_0000);
		queue_update(CUR_1, CUR_0, ONE, 64'h1_0001);
		queue_update(CUR_1, CUR_1, ONE * 3, ONE);
		queue_update(CUR_2, CUR_2, ONE, '0);
		queue_update(CUR_COUNT, CUR_1, ALL_ONES, ALL_ONES);
		queue_update(CUR_0, CUR_COUNT, '0, '0);
		queue_update(CUR_COUNT, CUR_COUNT, ONE, ONE);
		queue_update(CUR_0, CUR_2, ONE, ONE);
		queue_update(CUR_2, CUR_1, ONE, ONE);
		queue_update(CUR_1, CUR_0, ONE, ONE);
		// saturated operand carried through the rest of the cycle
		queue_update(CUR_0, CUR_1, 64'h8000_0000_0000_0000, ONE);
		queue_update(CUR_1, CUR_2, ALL_ONES, 64'd3);
		queue_update(CUR_0, CUR_1, ONE, ONE);
		queue_update(CUR_1, CUR_2, ONE + 1, ONE - 1);
		wait_idle();

		write_fee('0);
		queue_random(150);
		wait_idle();

		// long receiver hold-off fills the block and stalls its input
		write_fee(FEE_ONE);
		@(posedge clk);
		rx_hold_req = 1'b1;
		queue_random(150);
		wait_idle();

		write_fee(FEE_RESET);
		queue_random(100);
		drain_next = 1'b1;
		queue_random(100);
		wait_idle();

		// back to back, no idling on either side
		write_fee(random_fee());
		calm = 1'b1;
		queue_random(200);
		wait_idle();
		calm = 1'b0;

		write_fee(random_fee());
		@(posedge clk);
		rx_hold_req = 1'b1;
		queue_random(150);
		drain_next = 1'b1;
		queue_random(150);
		wait_idle();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d rate updates over %0d fee settings and %0d sender pauses,",
			updates_sent, fee_settings, sender_pauses);
		$display("%0d results checked, %0d saturating, %0d with zero sell, %0d errors",
			results_checked, sat_seen, zero_seen, errors);
		if (errors == 0 && pending_returns.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
src/tar_pkg.sv
src/tar_qmul.sv
src/tar_recip.sv
src/triangular_arbitrage_returns.sv
src/tar_checker.sv
sim/tb.sv
